[src/saf_pkg.sv]
// Shared types, register and mode codes, and helpers for the sample filter.
`timescale 1ns / 1ps
package saf_pkg;

  localparam logic [2:0] CFG_MODE   = 3'd0;
  localparam logic [2:0] CFG_SCALAR = 3'd1;
  localparam logic [2:0] CFG_CLAMP  = 3'd2;
  localparam logic [2:0] CFG_MIN    = 3'd3;
  localparam logic [2:0] CFG_MAX    = 3'd4;

  localparam logic [3:0] MODE_ADD   = 4'd0;
  localparam logic [3:0] MODE_SUB   = 4'd1;
  localparam logic [3:0] MODE_MUL   = 4'd2;
  localparam logic [3:0] MODE_DIV   = 4'd3;
  localparam logic [3:0] MODE_EADD  = 4'd4;
  localparam logic [3:0] MODE_ESUB  = 4'd5;
  localparam logic [3:0] MODE_EMUL  = 4'd6;
  localparam logic [3:0] MODE_EDIV  = 4'd7;
  localparam logic [3:0] MODE_THR   = 4'd8;
  localparam logic [3:0] MODE_BTHR  = 4'd9;
  localparam logic [3:0] MODE_AVG   = 4'd10;
  localparam logic [3:0] MODE_GRAD  = 4'd11;
  localparam logic [3:0] MODE_AGRAD = 4'd12;
  localparam logic [3:0] MODE_INV   = 4'd13;

  typedef struct packed {
    logic [3:0]          mode;
    logic signed [15:0]  scalar;
    logic                clamp_en;
    logic signed [31:0]  min_val;
    logic signed [31:0]  max_val;
  } cfg_t;

  // Window length: the scalar operand saturated to 1..wmax.
  function automatic int unsigned saf_win_len(input logic signed [15:0] s,
                                              input int unsigned wmax);
    int sv;
    sv = int'(s);
    if (sv < 1) begin
      saf_win_len = 1;
    end else if (sv > int'(wmax)) begin
      saf_win_len = wmax;
    end else begin
      saf_win_len = unsigned'(sv);
    end
  endfunction

endpackage

[src/saf_front.sv]
// Front end: accepts input words, tracks position and first sample, plans result range.
`timescale 1ns / 1ps
module saf_front #(
  parameter int WMAX = 64,
  parameter int SB   = 16,
  parameter int LW   = 7,
  parameter int EW   = 3 * 16 + 3 * 7 + 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic signed [SB-1:0] in_sample,
  input  logic signed [SB-1:0] in_other_sample,
  input  logic                 in_last,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  saf_pkg::cfg_t        cfg,
  input  logic                 q_full,
  output logic                 q_push,
  output logic [EW-1:0]        q_data
);
  import saf_pkg::*;

  logic [LW-1:0]        n_r;
  logic signed [SB-1:0] first_r;
  logic [LW-1:0]        w;
  logic [LW-1:0]        lead;
  logic                 n_ge;
  logic [LW-1:0]        start_pos;
  logic [LW-1:0]        end_pos;
  logic                 has_res;
  logic signed [SB-1:0] first_val;

  assign w = LW'(saf_win_len(cfg.scalar, WMAX));

  always_comb begin
    if (cfg.mode == MODE_AVG) begin
      lead = w - LW'(1) - (w >> 1);
    end else if (cfg.mode == MODE_GRAD || cfg.mode == MODE_AGRAD) begin
      lead = LW'(1);
    end else begin
      lead = '0;
    end
  end

  assign n_ge      = n_r >= lead;
  assign start_pos = n_ge ? n_r - lead : '0;
  assign end_pos   = in_last ? n_r : start_pos;
  assign has_res   = in_last || n_ge;
  assign first_val = (n_r == '0) ? in_sample : first_r;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_data   = {in_sample, in_other_sample, first_val, n_r, start_pos, end_pos,
                     in_last, has_res};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= '0;
    end else if (q_push) begin
      if (in_last) begin
        n_r <= '0;
      end else if (n_r < LW'(WMAX)) begin
        n_r <= n_r + LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      first_r <= first_val;
    end
  end

endmodule

[src/saf_queue.sv]
// Two-entry queue between the front and back ends.
`timescale 1ns / 1ps
module saf_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] head
);
  logic [W-1:0] mem_r [2];
  logic         wp_r;
  logic         rp_r;
  logic [1:0]   cnt_r;

  assign full  = cnt_r == 2'd2;
  assign valid = cnt_r != 2'd0;
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

[src/saf_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module saf_div #(
  parameter int W = 25
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] quo
);
  localparam int CW = $clog2(W + 1);

  logic [W:0]    rem_r;
  logic [W-1:0]  quo_r;
  logic [W-1:0]  den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [W:0]    sh;
  logic          ge;

  assign sh   = {rem_r[W-1:0], quo_r[W-1]};
  assign ge   = sh >= {1'b0, den_r};
  assign done = done_r;
  assign quo  = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? sh - {1'b0, den_r} : sh;
      quo_r <= {quo_r[W-2:0], ge};
    end
  end

endmodule

[src/saf_back.sv]
// Back end: history memory, per-result window fetch, arithmetic, clamp and output register.
`timescale 1ns / 1ps
module saf_back #(
  parameter int WMAX = 64,
  parameter int SB   = 16,
  parameter int LW   = 7,
  parameter int AW   = 6,
  parameter int EW   = 3 * 16 + 3 * 7 + 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  saf_pkg::cfg_t       cfg,
  input  logic                q_valid,
  input  logic [EW-1:0]       q_data,
  output logic                q_pop,
  output logic signed [31:0]  out_result,
  output logic                out_last_res,
  output logic                out_valid,
  input  logic                out_stall
);
  import saf_pkg::*;

  localparam int PB   = LW + 2;
  localparam int ACW  = SB + LW + 1;
  localparam int DVW  = (ACW + 1 > 17) ? ACW + 1 : 17;
  localparam int PRW  = SB + ((SB > 16) ? SB : 16);
  localparam int SATW = (PRW > 33) ? PRW : 33;

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_FETCH, S_ACCUM, S_EXEC, S_DIV, S_FIN, S_OUT, S_WRITE
  } state_t;
  typedef enum logic [1:0] {SRC_FIRST, SRC_CUR, SRC_MEM} src_t;

  state_t                 state_r;
  src_t                   src_r;
  logic [LW-1:0]          i_r;
  logic signed [PB-1:0]   p_r;
  logic [LW-1:0]          cnt_r;
  logic                   neg_r;
  logic signed [ACW-1:0]  acc_r;
  logic signed [SATW-1:0] raw_r;
  logic                   sign_r;
  logic [AW-1:0]          wr_pos_r;
  logic signed [31:0]     out_result_r;
  logic                   out_last_r;
  logic                   out_valid_r;
  logic signed [SB-1:0]   hist_r [WMAX];
  logic signed [SB-1:0]   rd_q_r;

  logic signed [SB-1:0]   q_cur, q_oth, q_first;
  logic [LW-1:0]          q_n, q_start, q_end;
  logic                   q_last, q_has;

  assign q_cur   = $signed(q_data[EW-1 -: SB]);
  assign q_oth   = $signed(q_data[EW-1-SB -: SB]);
  assign q_first = $signed(q_data[EW-1-2*SB -: SB]);
  assign q_n     = q_data[3*LW+1 -: LW];
  assign q_start = q_data[2*LW+1 -: LW];
  assign q_end   = q_data[LW+1 -: LW];
  assign q_last  = q_data[1];
  assign q_has   = q_data[0];

  logic [LW-1:0]          w, half;
  logic                   is_avg, is_grad;
  logic signed [PB-1:0]   n_s;
  logic [LW-1:0]          age;
  logic [AW+1:0]          addr_sum;
  logic [AW-1:0]          fetch_addr;
  logic signed [SB-1:0]   val;
  logic signed [SB-1:0]   x;
  logic signed [PRW-1:0]  prod_s, prod_o;
  logic signed [ACW-1:0]  gabs, gval;
  logic signed [SATW-1:0] direct;
  logic signed [DVW-1:0]  xd, accd, sd, od;
  logic [DVW-1:0]         xabs, accabs, sabs, oabs;
  logic [DVW-1:0]         div_num, div_den;
  logic                   div_sign, use_div, div_zero;
  logic                   div_start, div_done;
  logic [DVW-1:0]         div_quo;
  logic [SATW-32:0]       hi;
  logic signed [31:0]     sat_v, clamp_v;

  assign w       = LW'(saf_win_len(cfg.scalar, WMAX));
  assign half    = w >> 1;
  assign is_avg  = cfg.mode == MODE_AVG;
  assign is_grad = cfg.mode == MODE_GRAD || cfg.mode == MODE_AGRAD;

  // Position p maps to the entry age words behind the write pointer.
  assign n_s        = $signed({2'b00, q_n});
  assign age        = q_n - p_r[LW-1:0];
  assign addr_sum   = {2'b00, wr_pos_r} + (AW+2)'(WMAX) - (AW+2)'(age);
  assign fetch_addr = (addr_sum >= (AW+2)'(WMAX)) ? AW'(addr_sum - (AW+2)'(WMAX))
                                                  : AW'(addr_sum);

  always_comb begin
    unique case (src_r)
      SRC_FIRST: val = q_first;
      SRC_CUR:   val = q_cur;
      default:   val = rd_q_r;
    endcase
  end

  assign x      = acc_r[SB-1:0];
  assign prod_s = x * cfg.scalar;
  assign prod_o = x * q_oth;
  assign gabs   = (acc_r < 0) ? -acc_r : acc_r;
  assign gval   = (gabs + ACW'(1)) >>> 1;

  assign xd     = DVW'(x);
  assign accd   = DVW'(acc_r);
  assign sd     = DVW'(cfg.scalar);
  assign od     = DVW'(q_oth);
  assign xabs   = xd[DVW-1] ? unsigned'(-xd) : unsigned'(xd);
  assign accabs = accd[DVW-1] ? unsigned'(-accd) : unsigned'(accd);
  assign sabs   = sd[DVW-1] ? unsigned'(-sd) : unsigned'(sd);
  assign oabs   = od[DVW-1] ? unsigned'(-od) : unsigned'(od);

  always_comb begin
    direct   = '0;
    use_div  = 1'b0;
    div_zero = 1'b0;
    div_num  = xabs;
    div_den  = sabs;
    div_sign = 1'b0;
    unique case (cfg.mode)
      MODE_ADD:  direct = SATW'(x) + SATW'(cfg.scalar);
      MODE_SUB:  direct = SATW'(x) - SATW'(cfg.scalar);
      MODE_MUL:  direct = SATW'(prod_s);
      MODE_DIV: begin
        use_div  = 1'b1;
        div_zero = cfg.scalar == '0;
        div_sign = x[SB-1] ^ cfg.scalar[15];
      end
      MODE_EADD: direct = SATW'(x) + SATW'(q_oth);
      MODE_ESUB: direct = SATW'(x) - SATW'(q_oth);
      MODE_EMUL: direct = SATW'(prod_o);
      MODE_EDIV: begin
        use_div  = 1'b1;
        div_zero = q_oth == '0;
        div_den  = oabs;
        div_sign = x[SB-1] ^ q_oth[SB-1];
      end
      MODE_THR:  direct = (SATW'(x) < SATW'(cfg.scalar)) ? '0 : SATW'(x);
      MODE_BTHR: direct = (SATW'(x) < SATW'(cfg.scalar)) ? '0 : SATW'(1);
      MODE_AVG: begin
        use_div  = 1'b1;
        div_num  = (accabs << 1) + DVW'(w);
        div_den  = DVW'(w) << 1;
        div_sign = acc_r[ACW-1];
      end
      MODE_GRAD:  direct = (acc_r < 0) ? -SATW'(gval) : SATW'(gval);
      MODE_AGRAD: direct = SATW'(gval);
      MODE_INV:   direct = SATW'(cfg.max_val) - SATW'(x);
      default:    direct = '0;
    endcase
  end

  assign div_start = (state_r == S_EXEC) && use_div && !div_zero;

  saf_div #(.W(DVW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign hi    = raw_r[SATW-1:31];
  assign sat_v = ((&hi) || !(|hi)) ? raw_r[31:0]
               : (raw_r[SATW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff);

  always_comb begin
    clamp_v = sat_v;
    if (cfg.clamp_en) begin
      if (sat_v < cfg.min_val) begin
        clamp_v = cfg.min_val;
      end else if (sat_v > cfg.max_val) begin
        clamp_v = cfg.max_val;
      end
    end
  end

  assign q_pop        = state_r == S_WRITE;
  assign out_result   = out_result_r;
  assign out_last_res = out_last_r;
  assign out_valid    = out_valid_r;

  always_ff @(posedge clk) begin
    rd_q_r <= hist_r[fetch_addr];
    if (state_r == S_WRITE) begin
      hist_r[wr_pos_r] <= q_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wr_pos_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            i_r     <= q_start;
            state_r <= q_has ? S_SETUP : S_WRITE;
          end
        end
        S_SETUP: begin
          acc_r <= '0;
          neg_r <= 1'b0;
          if (is_avg) begin
            p_r   <= $signed(PB'(i_r)) - $signed(PB'(half));
            cnt_r <= w;
          end else if (is_grad) begin
            p_r   <= $signed(PB'(i_r)) + PB'(1);
            cnt_r <= LW'(2);
          end else begin
            p_r   <= $signed(PB'(i_r));
            cnt_r <= LW'(1);
          end
          state_r <= S_FETCH;
        end
        S_FETCH: begin
          if (p_r[PB-1]) begin
            src_r <= SRC_FIRST;
          end else if (p_r >= n_s) begin
            src_r <= SRC_CUR;
          end else begin
            src_r <= SRC_MEM;
          end
          state_r <= S_ACCUM;
        end
        S_ACCUM: begin
          acc_r <= neg_r ? acc_r - ACW'(val) : acc_r + ACW'(val);
          neg_r <= is_grad;
          p_r   <= is_grad ? p_r - PB'(2) : p_r + PB'(1);
          cnt_r <= cnt_r - LW'(1);
          state_r <= (cnt_r == LW'(1)) ? S_EXEC : S_FETCH;
        end
        S_EXEC: begin
          sign_r <= div_sign;
          if (use_div && !div_zero) begin
            state_r <= S_DIV;
          end else begin
            raw_r   <= direct;
            state_r <= S_FIN;
          end
        end
        S_DIV: begin
          if (div_done) begin
            raw_r   <= sign_r ? -$signed(SATW'(div_quo)) : $signed(SATW'(div_quo));
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          out_result_r <= clamp_v;
          out_last_r   <= q_last && (i_r == q_end);
          out_valid_r  <= 1'b1;
          state_r      <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (i_r == q_end) begin
              state_r <= S_WRITE;
            end else begin
              i_r     <= i_r + LW'(1);
              state_r <= S_SETUP;
            end
          end
        end
        S_WRITE: begin
          if (q_last || wr_pos_r == AW'(WMAX - 1)) begin
            wr_pos_r <= '0;
          end else begin
            wr_pos_r <= wr_pos_r + AW'(1);
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |-> state_r == S_IDLE)
    else $error("back end busy without a queued word");
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside the divide state");
  a_valid_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_OUT)
    else $error("result valid outside the output state");
`endif

endmodule

[src/sample_arith_filter_clamp_unit.sv]
// Top level of the sample arithmetic, filter and clamp unit.
//
//   channel  direction  handshake             contents
//   in       input      in_valid / in_stall   sample, other sample, last
//   out      output     out_valid / out_stall result, last mark
//   cfg      input      cfg_we                register index and write data
//
// Each result runs setup, a fetch and an accumulate step per window sample, execute and finish.
// Average and divide modes also run the iterative divider; the divider is
// (SAMPLE_BITS + clog2(WINDOW_MAX+1) + 2) bits wide, at least 17, and a zero divisor skips it.
// Each word also passes through dispatch and the history write.
// The back end handles one word at a time; the two-entry queue keeps taking words meanwhile until it is full.
// Reset is synchronous and active low and clears control state only.
// A stalled result holds in the output register and freezes the back end.
`timescale 1ns / 1ps
module sample_arith_filter_clamp_unit #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic signed [SAMPLE_BITS-1:0] in_other_sample,
  input  logic                          in_last,
  input  logic                          in_valid,
  output logic                          in_stall,
  output logic signed [31:0]            out_result,
  output logic                          out_last_res,
  output logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [31:0]                   cfg_wdata
);
  import saf_pkg::*;

  localparam int LW = $clog2(WINDOW_MAX + 1);
  localparam int AW = $clog2(WINDOW_MAX);
  localparam int EW = 3 * SAMPLE_BITS + 3 * LW + 2;

  cfg_t          cfg_r;
  logic          q_full, q_push, q_pop, q_valid;
  logic [EW-1:0] q_in, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode     <= MODE_ADD;
      cfg_r.scalar   <= '0;
      cfg_r.clamp_en <= 1'b0;
      cfg_r.min_val  <= '0;
      cfg_r.max_val  <= 32'sd255;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:   cfg_r.mode     <= cfg_wdata[3:0];
        CFG_SCALAR: cfg_r.scalar   <= $signed(cfg_wdata[15:0]);
        CFG_CLAMP:  cfg_r.clamp_en <= cfg_wdata[0];
        CFG_MIN:    cfg_r.min_val  <= $signed(cfg_wdata);
        CFG_MAX:    cfg_r.max_val  <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  saf_front #(.WMAX(WINDOW_MAX), .SB(SAMPLE_BITS), .LW(LW), .EW(EW)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_sample       (in_sample),
    .in_other_sample (in_other_sample),
    .in_last         (in_last),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .cfg             (cfg_r),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_data          (q_in)
  );

  saf_queue #(.W(EW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  saf_back #(.WMAX(WINDOW_MAX), .SB(SAMPLE_BITS), .LW(LW), .AW(AW), .EW(EW)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .q_valid      (q_valid),
    .q_data       (q_head),
    .q_pop        (q_pop),
    .out_result   (out_result),
    .out_last_res (out_last_res),
    .out_valid    (out_valid),
    .out_stall    (out_stall)
  );

endmodule

[bench/tb_sample_arith_filter_clamp_unit.sv]
// Testbench for the sample arithmetic, filter and clamp unit: directed table plus random streams.
`timescale 1ns / 1ps
module tb_sample_arith_filter_clamp_unit;
  import saf_pkg::*;

  localparam int WMAX = 64;
  localparam int SETTLE = 600;
  localparam logic [3:0] MODE_SPARE_A = 4'd14;
  localparam logic [3:0] MODE_SPARE_B = 4'd15;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic signed [15:0] in_sample = '0;
  logic signed [15:0] in_other_sample = '0;
  logic in_last = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] out_result;
  logic out_last_res;
  logic out_valid;
  logic out_stall = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = CFG_MODE;
  logic [31:0] cfg_wdata = '0;

  sample_arith_filter_clamp_unit uut (.*);

  always #5 clk = ~clk;

  cfg_t cur_cfg;
  logic signed [15:0] hist [WMAX];
  longint first_smp;
  int unsigned sig_pos;
  int unsigned wr_ptr;
  int snd_idle = 0;
  int rcv_idle = 0;
  int errors = 0;
  logic signed [31:0] filtered_q [$];
  logic last_mark_q [$];

  typedef struct {
    logic [3:0] mode;
    logic signed [15:0] scalar;
    logic signed [15:0] smp;
    logic signed [15:0] oth;
    logic last;
    bit typed;
    int want;
  } row_t;

  function automatic longint round_half_away(longint num, longint den);
    longint a;
    longint q;
    a = num < 0 ? -num : num;
    q = (2 * a + den) / (2 * den);
    return num < 0 ? -q : q;
  endfunction

  function automatic longint sat_to_int(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint window_len();
    if (cur_cfg.scalar < 1) return 1;
    if (cur_cfg.scalar > WMAX) return WMAX;
    return longint'(cur_cfg.scalar);
  endfunction

  function automatic longint value_at(longint p, longint n, longint cur);
    int unsigned d;
    if (p < 0) return first_smp;
    if (p >= n) return cur;
    d = int'((n - p) % WMAX);
    return longint'(hist[(wr_ptr + WMAX - d) % WMAX]);
  endfunction

  function automatic longint filtered_value(longint i, longint n, longint cur, longint oth);
    longint x;
    longint s;
    longint w;
    longint sum;
    longint g;
    x = value_at(i, n, cur);
    s = longint'(cur_cfg.scalar);
    case (cur_cfg.mode)
      MODE_ADD: return x + s;
      MODE_SUB: return x - s;
      MODE_MUL: return sat_to_int(x * s);
      MODE_DIV: return s == 0 ? 0 : x / s;
      MODE_EADD: return x + oth;
      MODE_ESUB: return x - oth;
      MODE_EMUL: return sat_to_int(x * oth);
      MODE_EDIV: return oth == 0 ? 0 : x / oth;
      MODE_THR: return x < s ? 0 : x;
      MODE_BTHR: return x < s ? 0 : 1;
      MODE_AVG: begin
        w = window_len();
        sum = 0;
        for (longint j = 0; j < w; j++) sum += value_at(i + j - w / 2, n, cur);
        return round_half_away(sum, w);
      end
      MODE_GRAD, MODE_AGRAD: begin
        g = round_half_away(value_at(i + 1, n, cur) - value_at(i - 1, n, cur), 2);
        if (cur_cfg.mode == MODE_AGRAD && g < 0) g = -g;
        return g;
      end
      MODE_INV: return sat_to_int(longint'(cur_cfg.max_val) - x);
      default: return 0;
    endcase
  endfunction

  task automatic predict_word(logic signed [15:0] smp, logic signed [15:0] oth, logic lst);
    longint n;
    longint lead;
    longint lo;
    longint hi;
    longint v;
    n = sig_pos;
    lead = 0;
    if (n == 0) first_smp = smp;
    if (cur_cfg.mode == MODE_AVG) begin
      lead = window_len() - 1 - window_len() / 2;
    end else if (cur_cfg.mode == MODE_GRAD || cur_cfg.mode == MODE_AGRAD) begin
      lead = 1;
    end
    if (lst) begin
      lo = n >= lead ? n - lead : 0;
      hi = n;
    end else begin
      lo = n - lead;
      hi = n < lead ? lo - 1 : lo;
    end
    for (longint i = lo; i <= hi; i++) begin
      v = filtered_value(i, n, smp, oth);
      if (cur_cfg.clamp_en) begin
        if (v < cur_cfg.min_val) v = cur_cfg.min_val;
        else if (v > cur_cfg.max_val) v = cur_cfg.max_val;
      end
      filtered_q.push_back(32'(v));
      last_mark_q.push_back(lst && i == hi);
    end
    hist[wr_ptr] = smp;
    wr_ptr = (wr_ptr + 1) % WMAX;
    if (lst) begin
      sig_pos = 0;
      wr_ptr = 0;
    end else if (sig_pos < WMAX) begin
      sig_pos++;
    end
  endtask

  task automatic send_word(logic signed [15:0] smp, logic signed [15:0] oth, logic lst);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= smp;
    in_other_sample <= oth;
    in_last <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_word(smp, oth, lst);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (filtered_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic load_config(cfg_t c);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    write_reg(CFG_MODE, {28'd0, c.mode});
    write_reg(CFG_SCALAR, {{16{c.scalar[15]}}, c.scalar});
    write_reg(CFG_CLAMP, {31'd0, c.clamp_en});
    write_reg(CFG_MIN, c.min_val);
    write_reg(CFG_MAX, c.max_val);
    cfg_we <= 1'b0;
    cur_cfg = c;
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(20)) - 16'sd10;
      default: return 16'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rcv_idle);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (filtered_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual result %0d last %0b",
                 $time, out_result, out_last_res);
        errors++;
      end else begin
        if (out_result !== filtered_q[0]) begin
          $display("%0t: result mismatch, expected %0d, actual %0d",
                   $time, filtered_q[0], out_result);
          errors++;
        end
        if (out_last_res !== last_mark_q[0]) begin
          $display("%0t: last mark mismatch, expected %0b, actual %0b",
                   $time, last_mark_q[0], out_last_res);
          errors++;
        end
        void'(filtered_q.pop_front());
        void'(last_mark_q.pop_front());
      end
    end
  end

  initial begin
    #200_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    row_t dir_rows [$];
    cfg_t c;
    int lim;
    int cnt;
    int len;
    cur_cfg = '{mode: MODE_ADD, scalar: 16'sd0, clamp_en: 1'b0, min_val: 32'sd0,
                max_val: 32'sd255};
    first_smp = 0;
    sig_pos = 0;
    wr_ptr = 0;
    for (int k = 0; k < WMAX; k++) hist[k] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dir_rows = '{
      '{MODE_ADD, 16'sh7fff, 16'sh7fff, 16'sd0, 1'b1, 1, 65534},
      '{MODE_ADD, 16'sh8000, 16'sh8000, 16'sd0, 1'b1, 1, -65536},
      '{MODE_SUB, 16'sh7fff, 16'sh8000, 16'sd0, 1'b1, 1, -65535},
      '{MODE_MUL, 16'sh8000, 16'sh8000, 16'sd0, 1'b1, 1, 1073741824},
      '{MODE_DIV, 16'sd0, 16'sd1234, 16'sd0, 1'b1, 1, 0},
      '{MODE_DIV, 16'sd7, -16'sd100, 16'sd0, 1'b1, 1, -14},
      '{MODE_EADD, 16'sd0, 16'sh7fff, 16'sh7fff, 1'b1, 1, 65534},
      '{MODE_ESUB, 16'sd0, 16'sh8000, 16'sh7fff, 1'b1, 1, -65535},
      '{MODE_EMUL, 16'sd0, 16'sh7fff, 16'sh8000, 1'b1, 1, -1073709056},
      '{MODE_EDIV, 16'sd0, 16'sd5, 16'sd0, 1'b1, 1, 0},
      '{MODE_THR, 16'sd10, 16'sd9, 16'sd0, 1'b1, 1, 0},
      '{MODE_BTHR, 16'sd10, 16'sd10, 16'sd0, 1'b1, 1, 1},
      '{MODE_INV, 16'sd0, 16'sh8000, 16'sd0, 1'b1, 1, 33023},
      '{MODE_SPARE_A, 16'sd0, 16'sd77, 16'sd3, 1'b1, 1, 0},
      '{MODE_SPARE_B, 16'sd0, 16'sd77, 16'sd3, 1'b1, 1, 0},
      '{MODE_AVG, 16'sd0, 16'sd13, 16'sd0, 1'b1, 0, 0},
      '{MODE_AVG, 16'sd3, 16'sd10, 16'sd0, 1'b0, 0, 0},
      '{MODE_AVG, 16'sd3, 16'sd20, 16'sd0, 1'b0, 0, 0},
      '{MODE_AVG, 16'sd3, 16'sd41, 16'sd0, 1'b1, 0, 0},
      '{MODE_GRAD, 16'sd0, 16'sd0, 16'sd0, 1'b0, 0, 0},
      '{MODE_GRAD, 16'sd0, 16'sd101, 16'sd0, 1'b0, 0, 0},
      '{MODE_GRAD, 16'sd0, -16'sd50, 16'sd0, 1'b1, 0, 0},
      '{MODE_AGRAD, 16'sd0, 16'sd0, 16'sd0, 1'b0, 0, 0},
      '{MODE_AGRAD, 16'sd0, 16'sd101, 16'sd0, 1'b0, 0, 0},
      '{MODE_AGRAD, 16'sd0, -16'sd50, 16'sd0, 1'b1, 0, 0}
    };
    foreach (dir_rows[r]) begin
      if (dir_rows[r].mode != cur_cfg.mode || dir_rows[r].scalar != cur_cfg.scalar) begin
        c = cur_cfg;
        c.mode = dir_rows[r].mode;
        c.scalar = dir_rows[r].scalar;
        load_config(c);
      end
      send_word(dir_rows[r].smp, dir_rows[r].oth, dir_rows[r].last);
      if (dir_rows[r].typed) filtered_q[filtered_q.size() - 1] = dir_rows[r].want;
    end

    for (int ph = 0; ph < 8; ph++) begin
      snd_idle = ph < 3 ? 33 : (ph < 6 ? 54 : 0);
      rcv_idle = ph < 3 ? 54 : (ph < 6 ? 33 : 0);
      c.mode = 4'($urandom_range(15));
      c.scalar = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(12)) - 16'sd2;
      c.clamp_en = 1'($urandom);
      c.min_val = -32'($urandom_range(40000));
      c.max_val = 32'($urandom_range(40000));
      case (ph)
        0: begin c.mode = MODE_AVG; c.scalar = 16'sd64; end
        1: begin c.min_val = 32'sh8000_0000; c.max_val = 32'sh7fff_ffff; end
        2: begin c.scalar = 16'sh8000; c.min_val = 32'sd500; c.max_val = -32'sd500;
                 c.clamp_en = 1'b1; end
        3: begin c.scalar = 16'sh7fff; c.max_val = 32'sh7fff_ffff; c.mode = MODE_INV; end
        4: begin c.mode = MODE_INV; c.max_val = 32'sh8000_0000; c.min_val = 32'sh7fff_ffff; end
        5: c.mode = MODE_GRAD + 4'($urandom_range(1));
        default: ;
      endcase
      load_config(c);
      cnt = 0;
      lim = 24;
      while (cnt < lim) begin
        len = $urandom_range(9) == 0 ? $urandom_range(80, 40) : $urandom_range(12, 1);
        if (ph == 4 && cnt == 0) wait_drained();
        for (int k = 0; k < len && cnt < lim + 40; k++) begin
          send_word(rand_sample(), $urandom_range(7) == 0 ? 16'sd0 : rand_sample(),
                    k == len - 1);
          cnt++;
        end
      end
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
